>>> rtl/core/qs3_pkg.sv
// ----------------------------------------------------------------------------
// qs3_pkg
// Shared constants and types for the three-way quicksort block.
// ----------------------------------------------------------------------------
package qs3_pkg;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned VALUE_WIDTH = 32;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_W = 2 * CNT_W;

  typedef logic [VALUE_WIDTH-1:0] val_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef struct packed {
    cnt_t last;
    cnt_t first;
  } range_t;

  // signed order on stored values
  function automatic logic val_lt(val_t a, val_t b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

>>> rtl/core/qs3_ram.sv
// ----------------------------------------------------------------------------
// qs3_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module qs3_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold read data when no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> rtl/core/quicksort_three_way_sorter.sv
// Load: one input beat per cycle; stalled while a run is sorted or emitted.
// Sort: two partition passes per range (values below the pivot, then values
// equal to it), one element RAM read per step through its registered read
// port; a swap adds a read and two writes, and each range adds pivot and stack steps.
// Emit: each output beat is read from the RAM, then presented.
// Reset: asynchronous, clears count, stack pointer, overflow flag and the FSM;
// RAM contents are not cleared, no clearing pass.
// ----------------------------------------------------------------------------
// quicksort_three_way_sorter
// Collects a run of signed values, sorts it by three-way quicksort held in
// an element RAM with an explicit range stack RAM, then streams it out.
// ----------------------------------------------------------------------------
module quicksort_three_way_sorter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [31:0]              value_i,
  input  logic                     is_last_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [31:0]              sorted_value_o,
  output logic                     end_of_run_o,
  output logic                     overflowed_o
);
  import qs3_pkg::*;

  typedef enum logic [13:0] {
    S_LOAD  = 14'b00000000000001,
    S_START = 14'b00000000000010,
    S_POP   = 14'b00000000000100,
    S_POPW  = 14'b00000000001000,
    S_PIVRD = 14'b00000000010000,
    S_PIVW  = 14'b00000000100000,
    S_RD    = 14'b00000001000000,
    S_CHK   = 14'b00000010000000,
    S_SW1   = 14'b00000100000000,
    S_SW2   = 14'b00001000000000,
    S_PUSH1 = 14'b00010000000000,
    S_PUSH2 = 14'b00100000000000,
    S_OUTRD = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  cnt_t   count_q, count_d;
  cnt_t   sp_q, sp_d;
  logic   ovf_q, ovf_d;
  cnt_t   first_q, first_d, last_q, last_d;
  cnt_t   i_q, i_d, m_q, m_d, m1_q, m1_d, m2_q, m2_d, k_q, k_d;
  logic   pass_q, pass_d;
  val_t   pv_q, pv_d, hold_q, hold_d;

  logic   e_we, e_re;
  idx_t   e_waddr, e_raddr;
  val_t   e_wdata, e_rdata;
  logic   s_we, s_re;
  idx_t   s_waddr, s_raddr;
  range_t s_wdata, s_rdata;

  logic   in_acc, out_acc, hit;
  cnt_t   half, pivot_pos;

  assign in_stall_o  = (state_q != S_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;

  assign sorted_value_o = e_rdata;
  assign end_of_run_o   = (k_q == count_q - cnt_t'(1));
  assign overflowed_o   = ovf_q;

  assign half      = (last_q - first_q) >> 1;
  assign pivot_pos = first_q + half;
  assign hit       = val_lt(e_rdata, pv_q) || (pass_q && !val_lt(pv_q, e_rdata));

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    sp_d    = sp_q;
    ovf_d   = ovf_q;
    first_d = first_q;
    last_d  = last_q;
    i_d     = i_q;
    m_d     = m_q;
    m1_d    = m1_q;
    m2_d    = m2_q;
    k_d     = k_q;
    pass_d  = pass_q;
    pv_d    = pv_q;
    hold_d  = hold_q;
    e_we    = 1'b0;
    e_waddr = count_q[IDX_W-1:0];
    e_wdata = value_i;
    e_re    = 1'b0;
    e_raddr = i_q[IDX_W-1:0];
    s_we    = 1'b0;
    s_waddr = sp_q[IDX_W-1:0];
    s_wdata = '{last: m1_q, first: first_q};
    s_re    = 1'b0;
    s_raddr = idx_t'(sp_q - cnt_t'(1));

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (count_q < cnt_t'(CAPACITY)) begin
            e_we    = 1'b1;
            count_d = count_q + cnt_t'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (is_last_i) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        sp_d    = '0;
        first_d = '0;
        last_d  = count_q;
        k_d     = '0;
        state_d = (count_q > cnt_t'(1)) ? S_PIVRD : S_OUTRD;
      end
      S_POP: begin
        if (sp_q == '0) begin
          k_d     = '0;
          state_d = S_OUTRD;
        end else begin
          s_re    = 1'b1;
          sp_d    = sp_q - cnt_t'(1);
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        first_d = s_rdata.first;
        last_d  = s_rdata.last;
        state_d = S_PIVRD;
      end
      S_PIVRD: begin
        e_re    = 1'b1;
        e_raddr = pivot_pos[IDX_W-1:0];
        state_d = S_PIVW;
      end
      S_PIVW: begin
        pv_d    = e_rdata;
        i_d     = first_q;
        m_d     = first_q;
        pass_d  = 1'b0;
        state_d = S_RD;
      end
      S_RD: begin
        if (i_q == last_q) begin
          if (!pass_q) begin
            // second pass gathers values equal to the pivot
            m1_d   = m_q;
            i_d    = m_q;
            pass_d = 1'b1;
          end else begin
            m2_d    = m_q;
            state_d = S_PUSH1;
          end
        end else begin
          e_re    = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (!hit) begin
          i_d     = i_q + cnt_t'(1);
          state_d = S_RD;
        end else if (i_q == m_q) begin
          i_d     = i_q + cnt_t'(1);
          m_d     = m_q + cnt_t'(1);
          state_d = S_RD;
        end else begin
          hold_d  = e_rdata;
          e_re    = 1'b1;
          e_raddr = m_q[IDX_W-1:0];
          state_d = S_SW1;
        end
      end
      S_SW1: begin
        e_we    = 1'b1;
        e_waddr = i_q[IDX_W-1:0];
        e_wdata = e_rdata;
        state_d = S_SW2;
      end
      S_SW2: begin
        e_we    = 1'b1;
        e_waddr = m_q[IDX_W-1:0];
        e_wdata = hold_q;
        i_d     = i_q + cnt_t'(1);
        m_d     = m_q + cnt_t'(1);
        state_d = S_RD;
      end
      S_PUSH1: begin
        if (m1_q - first_q > cnt_t'(1)) begin
          s_we = 1'b1;
          sp_d = sp_q + cnt_t'(1);
        end
        state_d = S_PUSH2;
      end
      S_PUSH2: begin
        s_wdata = '{last: last_q, first: m2_q};
        if (last_q - m2_q > cnt_t'(1)) begin
          s_we = 1'b1;
          sp_d = sp_q + cnt_t'(1);
        end
        state_d = S_POP;
      end
      S_OUTRD: begin
        e_re    = 1'b1;
        e_raddr = k_q[IDX_W-1:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          if (end_of_run_o) begin
            count_d = '0;
            sp_d    = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + cnt_t'(1);
            state_d = S_OUTRD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      sp_q    <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sp_q    <= sp_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    last_q  <= last_d;
    i_q     <= i_d;
    m_q     <= m_d;
    m1_q    <= m1_d;
    m2_q    <= m2_d;
    k_q     <= k_d;
    pass_q  <= pass_d;
    pv_q    <= pv_d;
    hold_q  <= hold_d;
  end

  qs3_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .re_i    (e_re),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  qs3_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENT_W)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(CAPACITY))
    else $error("element count above capacity");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> (i_q < last_q && m_q <= i_q))
    else $error("partition scan outside its range");

  a_out_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_q != '0 && k_q < count_q))
    else $error("output beat from an empty run");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= cnt_t'(CAPACITY))
    else $error("range stack overflow");

  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && end_of_run_o) |=> (count_q == '0 && !ovf_q))
    else $error("run state not cleared after last beat");
`endif

endmodule

>>> tb/quicksort_three_way_sorter_tb.sv
// ----------------------------------------------------------------------------
// quicksort_three_way_sorter_tb
// Feeds runs of signed values with random gaps and output stalls, sorts each
// run in the bench, and compares every output beat against the sorted list.
// ----------------------------------------------------------------------------
module quicksort_three_way_sorter_tb;
  import qs3_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        is_last;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] value;
    logic        end_of_run;
    logic        overflowed;
  } out_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] value_i;
  logic        is_last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] sorted_value_o;
  logic        end_of_run_o;
  logic        overflowed_o;

  quicksort_three_way_sorter dut (.*);

  in_beat_t  pending_beats[$];
  out_beat_t sorted_expect[$];
  logic [31:0] run_values[$];
  logic        run_overflow;
  int          mismatches;
  bit          stim_done;
  bit          calm;
  int          in_gap;
  int          out_gap;
  // sampled stall at the accepting edge, so the driver knows what was taken
  logic        in_stall_o_q;

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // Store one accepted beat; at end of run, sort ascending and queue results.
  task automatic accept_element(in_beat_t b);
    logic [31:0] srt[$];
    logic [31:0] t;
    if (run_values.size() < CAPACITY) begin
      run_values.push_back(b.value);
    end else begin
      run_overflow = 1'b1;
    end
    if (b.is_last) begin
      srt = run_values;
      for (int i = 1; i < srt.size(); i++) begin
        t = srt[i];
        for (int j = i; j > 0 && $signed(srt[j-1]) > $signed(t); j--) begin
          srt[j] = srt[j-1];
          srt[j-1] = t;
        end
      end
      foreach (srt[k]) begin
        sorted_expect.push_back('{srt[k], k == srt.size() - 1, run_overflow});
      end
      run_values.delete();
      run_overflow = 1'b0;
    end
  endtask

  function automatic logic [31:0] rand_value(int mode);
    case (mode)
      0: return $urandom_range(0, 7) - 4;
      1: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom_range(0, 3))};
      default: return $urandom;
    endcase
  endfunction

  task automatic add_run(int len, int mode);
    for (int i = 0; i < len; i++) begin
      pending_beats.push_back('{rand_value(mode), i == len - 1});
    end
  endtask

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
      is_last_i  <= 1'b0;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o_q) begin
        void'(pending_beats.pop_front());
      end
      if (in_valid_i && in_stall_o_q) begin
        // hold the stalled beat
      end else if (in_gap > 0) begin
        in_gap     <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        if (!calm && $urandom_range(0, 7) == 0) begin
          in_gap     <= $urandom_range(1, 17) - 1;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          value_i    <= pending_beats[0].value;
          is_last_i  <= pending_beats[0].is_last;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    in_stall_o_q <= in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      accept_element('{value_i, is_last_i});
    end
  end

  // receiver stall
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_gap     <= 0;
    end else if (out_gap > 0) begin
      out_gap     <= out_gap - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_gap     <= $urandom_range(1, 17) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_beat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sorted_expect.size() == 0) begin
        $error("unexpected beat: sorted_value %0d", $signed(sorted_value_o));
        mismatches++;
      end else begin
        e = sorted_expect.pop_front();
        if (sorted_value_o !== e.value) begin
          $error("sorted_value: expected %0d actual %0d",
                 $signed(e.value), $signed(sorted_value_o));
          mismatches++;
        end
        if (end_of_run_o !== e.end_of_run) begin
          $error("end_of_run: expected %0b actual %0b", e.end_of_run, end_of_run_o);
          mismatches++;
        end
        if (overflowed_o !== e.overflowed) begin
          $error("overflowed: expected %0b actual %0b", e.overflowed, overflowed_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int len;
    mismatches   = 0;
    run_overflow = 1'b0;
    calm         = 1'b0;
    in_stall_o_q = 1'b1;
    rst_ni       = 1'b0;
    // directed runs: single element, pair, extremes, duplicates, overflow
    pending_beats.push_back('{32'h8000_0000, 1'b1});
    pending_beats.push_back('{32'h7FFF_FFFF, 1'b0});
    pending_beats.push_back('{32'h8000_0000, 1'b1});
    pending_beats.push_back('{32'h0000_0000, 1'b0});
    pending_beats.push_back('{32'hFFFF_FFFF, 1'b1});
    pending_beats.push_back('{32'd5, 1'b0});
    pending_beats.push_back('{32'd5, 1'b0});
    pending_beats.push_back('{32'hFFFF_FFFB, 1'b0});
    pending_beats.push_back('{32'd5, 1'b0});
    pending_beats.push_back('{32'h7FFF_FFFF, 1'b0});
    pending_beats.push_back('{32'h8000_0000, 1'b0});
    pending_beats.push_back('{32'd5, 1'b1});
    for (int i = 0; i < 67; i++) begin
      pending_beats.push_back('{32'($urandom), i == 66});
    end
    pending_beats.push_back('{32'h5555_5555, 1'b0});
    pending_beats.push_back('{32'hAAAA_AAAA, 1'b1});
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // random runs, mostly short
    for (int total = 0; total < 160; total += len) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 12);
      add_run(len, $urandom_range(0, 2));
    end
    while (pending_beats.size() >= 40) @(posedge clk_i);
    calm = 1'b1;
    while (pending_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    while (sorted_expect.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> quicksort_three_way_sorter.f
rtl/core/qs3_pkg.sv
rtl/core/qs3_ram.sv
rtl/core/quicksort_three_way_sorter.sv
tb/quicksort_three_way_sorter_tb.sv
